@@ rtl/paged_translation_fifo_replace_assert.svh @@
`ifndef PAGED_TRANSLATION_FIFO_REPLACE_ASSERT_SVH
`define PAGED_TRANSLATION_FIFO_REPLACE_ASSERT_SVH

// same-cycle implication
`define PTFR_ASSERT_NOW(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error(msg);

// delayed implication
`define PTFR_ASSERT_LATER(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> ##2 (c)) \
        else $error(msg);

`endif

@@ rtl/ptfr_pkg.sv @@
package ptfr_pkg;

    localparam int PAGES       = 16;
    localparam int PAGE_W      = 4;
    localparam int MAX_FRAMES  = 8;
    localparam int SLOT_W      = 3;
    localparam int COUNT_W     = 4;
    localparam int OFFSET_BITS = 12;
    localparam int FRAME_BITS  = 8;
    localparam int LIST_W      = 64;
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int ADDR_W      = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MASK  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NO_FRAMES = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

@@ rtl/paged_translation_fifo_replace.sv @@
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------------
// request  | start / busy               | i_page, i_offset, i_is_write
// result   | o_done (one-cycle strobe)  | o_status, o_phys_addr, o_fault,
//          |                            | o_dirty_evict, o_*_seen counters
// config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A request is captured in the idle state; the page table read-modify-write
// and slot lookup run in the exec state; o_done pulses the cycle after that.
// A new request may start in the cycle o_done is high. Reset is synchronous,
// active low, and clears the table and counters. The receiver cannot stall
// results.
`include "paged_translation_fifo_replace_assert.svh"

module paged_translation_fifo_replace (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [ptfr_pkg::PAGE_W-1:0]            i_page,
    input  logic [ptfr_pkg::OFFSET_BITS-1:0]       i_offset,
    input  logic                                   i_is_write,
    output logic                                   o_done,
    output logic [1:0]                             o_status,
    output logic [ptfr_pkg::ADDR_W-1:0]            o_phys_addr,
    output logic                                   o_fault,
    output logic                                   o_dirty_evict,
    output logic [ptfr_pkg::CNT_W-1:0]             o_reads_seen,
    output logic [ptfr_pkg::CNT_W-1:0]             o_writes_seen,
    output logic [ptfr_pkg::CNT_W-1:0]             o_faults_seen,
    output logic [ptfr_pkg::CNT_W-1:0]             o_dirty_evicts_seen,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ptfr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ptfr_pkg::LIST_W-1:0]            i_cfg_data
);

    ptfr_pkg::t_cmd cmd;

    ptfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .o_done  (o_done)
    );

    ptfr_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg_we            (i_cfg_valid && o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_page              (i_page),
        .i_offset            (i_offset),
        .i_is_write          (i_is_write),
        .o_status            (o_status),
        .o_phys_addr         (o_phys_addr),
        .o_fault             (o_fault),
        .o_dirty_evict       (o_dirty_evict),
        .o_reads_seen        (o_reads_seen),
        .o_writes_seen       (o_writes_seen),
        .o_faults_seen       (o_faults_seen),
        .o_dirty_evicts_seen (o_dirty_evicts_seen)
    );

    assign o_cfg_ready = !busy;

    `PTFR_ASSERT_LATER(a_done_follows, start && !busy, o_done, "request gave no result")
    `PTFR_ASSERT_NOW(a_done_idle, o_done, !busy, "result while still busy")
    `PTFR_ASSERT_NOW(a_wb_needs_fault, o_done && o_dirty_evict, o_fault, "write back without fault")
    `PTFR_ASSERT_NOW(a_fault_ok, o_done && o_fault, o_status == ptfr_pkg::ST_OK, "fault with error status")

endmodule

@@ rtl/ptfr_ctrl.sv @@
module ptfr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output ptfr_pkg::t_cmd  o_cmd,
    output logic            o_done
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cmd.load  = (r_state == S_IDLE) && start;
    assign o_cmd.exec  = (r_state == S_EXEC);
    assign o_done      = r_done;

endmodule

@@ rtl/ptfr_dp.sv @@
module ptfr_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ptfr_pkg::t_cmd                         i_cmd,
    input  logic                                   i_cfg_we,
    input  logic [ptfr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ptfr_pkg::LIST_W-1:0]            i_cfg_data,
    input  logic [ptfr_pkg::PAGE_W-1:0]            i_page,
    input  logic [ptfr_pkg::OFFSET_BITS-1:0]       i_offset,
    input  logic                                   i_is_write,
    output logic [1:0]                             o_status,
    output logic [ptfr_pkg::ADDR_W-1:0]            o_phys_addr,
    output logic                                   o_fault,
    output logic                                   o_dirty_evict,
    output logic [ptfr_pkg::CNT_W-1:0]             o_reads_seen,
    output logic [ptfr_pkg::CNT_W-1:0]             o_writes_seen,
    output logic [ptfr_pkg::CNT_W-1:0]             o_faults_seen,
    output logic [ptfr_pkg::CNT_W-1:0]             o_dirty_evicts_seen
);

    localparam logic [ptfr_pkg::CNT_W-1:0] SAT = '1;

    logic [ptfr_pkg::LIST_W-1:0]        r_frame_list;
    logic [ptfr_pkg::COUNT_W-1:0]       r_frame_count;
    logic [ptfr_pkg::PAGES-1:0]         r_valid_mask;

    logic [ptfr_pkg::PAGE_W-1:0]        r_page;
    logic [ptfr_pkg::OFFSET_BITS-1:0]   r_offset;
    logic                               r_is_write;

    logic [ptfr_pkg::PAGES-1:0]         r_present;
    logic [ptfr_pkg::PAGES-1:0]         n_present;
    logic [ptfr_pkg::SLOT_W-1:0]        r_pg_slot  [ptfr_pkg::PAGES];
    logic [ptfr_pkg::FRAME_BITS-1:0]    r_pg_frame [ptfr_pkg::PAGES];
    logic [ptfr_pkg::MAX_FRAMES-1:0]    r_slot_live;
    logic [ptfr_pkg::MAX_FRAMES-1:0]    r_slot_mod;
    logic [ptfr_pkg::PAGE_W-1:0]        r_slot_owner [ptfr_pkg::MAX_FRAMES];
    logic [ptfr_pkg::SLOT_W-1:0]        r_next_slot;

    logic [ptfr_pkg::CNT_W-1:0]         r_reads;
    logic [ptfr_pkg::CNT_W-1:0]         r_writes;
    logic [ptfr_pkg::CNT_W-1:0]         r_faults;
    logic [ptfr_pkg::CNT_W-1:0]         r_wbs;

    logic [1:0]                         r_status;
    logic [ptfr_pkg::ADDR_W-1:0]        r_addr;
    logic                               r_fault;
    logic                               r_wb;

    logic                               pg_valid;
    logic                               pg_present;
    logic [ptfr_pkg::SLOT_W-1:0]        pg_slot;
    logic [ptfr_pkg::COUNT_W-1:0]       count;
    logic [ptfr_pkg::SLOT_W-1:0]        slot;
    logic [ptfr_pkg::COUNT_W-1:0]       slot_inc;
    logic [ptfr_pkg::SLOT_W-1:0]        n_next_slot;
    logic [ptfr_pkg::PAGE_W-1:0]        victim;
    logic                               victim_wb;
    logic [ptfr_pkg::FRAME_BITS-1:0]    new_frame;
    logic [ptfr_pkg::FRAME_BITS-1:0]    use_frame;
    logic                               take_fault;
    logic                               no_frames;
    logic                               hit;
    logic [1:0]                         n_status;

    always_comb begin
        pg_valid    = r_valid_mask[r_page];
        pg_present  = r_present[r_page];
        pg_slot     = r_pg_slot[r_page];
        count       = (r_frame_count > ptfr_pkg::COUNT_W'(ptfr_pkg::MAX_FRAMES))
                      ? ptfr_pkg::COUNT_W'(ptfr_pkg::MAX_FRAMES) : r_frame_count;
        slot        = ({1'b0, r_next_slot} < count) ? r_next_slot : '0;
        slot_inc    = {1'b0, slot} + ptfr_pkg::COUNT_W'(1);
        n_next_slot = (slot_inc == count) ? '0 : slot_inc[ptfr_pkg::SLOT_W-1:0];
        victim      = r_slot_owner[slot];
        victim_wb   = r_slot_live[slot] && r_slot_mod[slot];
        new_frame   = r_frame_list[{slot, 3'b000} +: ptfr_pkg::FRAME_BITS];
        no_frames   = pg_valid && !pg_present && (count == '0);
        take_fault  = pg_valid && !pg_present && (count != '0);
        hit         = pg_valid && pg_present;
        use_frame   = take_fault ? new_frame : r_pg_frame[r_page];
        n_present   = r_present;
        if (take_fault) begin
            if (r_slot_live[slot]) begin
                n_present[victim] = 1'b0;
            end
            n_present[r_page] = 1'b1;
        end
        if (!pg_valid) begin
            n_status = ptfr_pkg::ST_INVALID;
        end else if (no_frames) begin
            n_status = ptfr_pkg::ST_NO_FRAMES;
        end else begin
            n_status = ptfr_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_list  <= '0;
            r_frame_count <= '0;
            r_valid_mask  <= '0;
            r_present     <= '0;
            r_slot_live   <= '0;
            r_next_slot   <= '0;
            r_reads       <= '0;
            r_writes      <= '0;
            r_faults      <= '0;
            r_wbs         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ptfr_pkg::CFG_FRAME_LIST:  r_frame_list  <= i_cfg_data;
                    ptfr_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[ptfr_pkg::COUNT_W-1:0];
                    ptfr_pkg::CFG_VALID_MASK:  r_valid_mask  <= i_cfg_data[ptfr_pkg::PAGES-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                if (r_is_write) begin
                    r_writes <= (r_writes == SAT) ? r_writes : r_writes + 1'b1;
                end else begin
                    r_reads <= (r_reads == SAT) ? r_reads : r_reads + 1'b1;
                end
                if (take_fault) begin
                    r_present          <= n_present;
                    r_slot_live[slot]  <= 1'b1;
                    r_next_slot        <= n_next_slot;
                    r_faults <= (r_faults == SAT) ? r_faults : r_faults + 1'b1;
                    if (victim_wb) begin
                        r_wbs <= (r_wbs == SAT) ? r_wbs : r_wbs + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page     <= i_page;
            r_offset   <= i_offset;
            r_is_write <= i_is_write;
        end
        if (i_cmd.exec) begin
            if (take_fault) begin
                r_slot_owner[slot] <= r_page;
                r_slot_mod[slot]   <= r_is_write;
                r_pg_slot[r_page]  <= slot;
                r_pg_frame[r_page] <= new_frame;
            end else if (hit && r_is_write) begin
                r_slot_mod[pg_slot] <= 1'b1;
            end
            r_status <= n_status;
            r_addr   <= (hit || take_fault) ? {use_frame, r_offset} : '0;
            r_fault  <= take_fault;
            r_wb     <= take_fault && victim_wb;
        end
    end

    assign o_status            = r_status;
    assign o_phys_addr         = r_addr;
    assign o_fault             = r_fault;
    assign o_dirty_evict       = r_wb;
    assign o_reads_seen        = r_reads;
    assign o_writes_seen       = r_writes;
    assign o_faults_seen       = r_faults;
    assign o_dirty_evicts_seen = r_wbs;

endmodule

@@ bench/paged_translation_fifo_replace_test.sv @@
`timescale 1ns / 1ps

module paged_translation_fifo_replace_test;

    localparam logic [ptfr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int NUM_PHASES = 6;
    localparam int PHASE_ITEMS = 160;

    typedef struct {
        ptfr_pkg::t_status           status;
        logic [ptfr_pkg::ADDR_W-1:0] phys;
        logic                        fault;
        logic                        dirty;
        logic [ptfr_pkg::CNT_W-1:0]  reads;
        logic [ptfr_pkg::CNT_W-1:0]  writes;
        logic [ptfr_pkg::CNT_W-1:0]  faults;
        logic [ptfr_pkg::CNT_W-1:0]  dirty_evicts;
    } t_xlat;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    logic [ptfr_pkg::PAGE_W-1:0]      i_page;
    logic [ptfr_pkg::OFFSET_BITS-1:0] i_offset;
    logic                             i_is_write;
    logic                             o_done;
    logic [1:0]                       o_status;
    logic [ptfr_pkg::ADDR_W-1:0]      o_phys_addr;
    logic                             o_fault;
    logic                             o_dirty_evict;
    logic [ptfr_pkg::CNT_W-1:0]       o_reads_seen;
    logic [ptfr_pkg::CNT_W-1:0]       o_writes_seen;
    logic [ptfr_pkg::CNT_W-1:0]       o_faults_seen;
    logic [ptfr_pkg::CNT_W-1:0]       o_dirty_evicts_seen;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [ptfr_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [ptfr_pkg::LIST_W-1:0]      i_cfg_data;

    paged_translation_fifo_replace dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_page              (i_page),
        .i_offset            (i_offset),
        .i_is_write          (i_is_write),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_phys_addr         (o_phys_addr),
        .o_fault             (o_fault),
        .o_dirty_evict       (o_dirty_evict),
        .o_reads_seen        (o_reads_seen),
        .o_writes_seen       (o_writes_seen),
        .o_faults_seen       (o_faults_seen),
        .o_dirty_evicts_seen (o_dirty_evicts_seen),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    logic [ptfr_pkg::LIST_W-1:0]     m_frame_list;
    logic [ptfr_pkg::COUNT_W-1:0]    m_frame_count;
    logic [ptfr_pkg::PAGES-1:0]      m_valid_mask;
    logic                            m_present    [ptfr_pkg::PAGES];
    logic                            m_referenced [ptfr_pkg::PAGES];
    logic                            m_modified   [ptfr_pkg::PAGES];
    logic [ptfr_pkg::FRAME_BITS-1:0] m_frame      [ptfr_pkg::PAGES];
    logic [ptfr_pkg::PAGE_W-1:0]     m_owner      [ptfr_pkg::MAX_FRAMES];
    logic                            m_live       [ptfr_pkg::MAX_FRAMES];
    logic [ptfr_pkg::SLOT_W-1:0]     m_next_slot;
    logic [ptfr_pkg::CNT_W-1:0]      m_reads;
    logic [ptfr_pkg::CNT_W-1:0]      m_writes;
    logic [ptfr_pkg::CNT_W-1:0]      m_faults;
    logic [ptfr_pkg::CNT_W-1:0]      m_wbs;

    t_xlat expected_xlat [$];
    int    errors;
    int    idle_pct;
    int    n_refs;
    int    n_invalid;
    int    n_no_frames;
    int    n_cfg;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("timeout at %0t with %0d results outstanding", $time, expected_xlat.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [ptfr_pkg::CNT_W-1:0] sat_inc(logic [ptfr_pkg::CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    task automatic reset_model();
        m_frame_list  = '0;
        m_frame_count = '0;
        m_valid_mask  = '0;
        for (int i = 0; i < ptfr_pkg::PAGES; i++) begin
            m_present[i]    = 1'b0;
            m_referenced[i] = 1'b0;
            m_modified[i]   = 1'b0;
            m_frame[i]      = '0;
        end
        for (int i = 0; i < ptfr_pkg::MAX_FRAMES; i++) begin
            m_owner[i] = '0;
            m_live[i]  = 1'b0;
        end
        m_next_slot = '0;
        m_reads     = '0;
        m_writes    = '0;
        m_faults    = '0;
        m_wbs       = '0;
    endtask

    function automatic t_xlat translate_ref(logic [ptfr_pkg::PAGE_W-1:0] page,
                                            logic [ptfr_pkg::OFFSET_BITS-1:0] offset,
                                            logic wr);
        t_xlat                       r;
        int                          count;
        int                          slot;
        logic [ptfr_pkg::PAGE_W-1:0] victim;
        r.status = ptfr_pkg::ST_OK;
        r.phys   = '0;
        r.fault  = 1'b0;
        r.dirty  = 1'b0;
        count = (m_frame_count > ptfr_pkg::MAX_FRAMES) ? ptfr_pkg::MAX_FRAMES
                                                        : int'(m_frame_count);
        if (wr) m_writes = sat_inc(m_writes);
        else m_reads = sat_inc(m_reads);
        if (!m_valid_mask[page]) begin
            r.status = ptfr_pkg::ST_INVALID;
            n_invalid++;
        end else if (!m_present[page] && count == 0) begin
            r.status = ptfr_pkg::ST_NO_FRAMES;
            n_no_frames++;
        end else begin
            if (!m_present[page]) begin
                slot = (int'(m_next_slot) < count) ? int'(m_next_slot) : 0;
                if (m_live[slot]) begin
                    victim = m_owner[slot];
                    if (m_modified[victim]) begin
                        r.dirty = 1'b1;
                        m_wbs = sat_inc(m_wbs);
                    end
                    m_present[victim] = 1'b0;
                end
                m_owner[slot]      = page;
                m_live[slot]       = 1'b1;
                m_present[page]    = 1'b1;
                m_referenced[page] = 1'b0;
                m_modified[page]   = 1'b0;
                m_frame[page]      = m_frame_list[8*slot +: ptfr_pkg::FRAME_BITS];
                m_next_slot        = ptfr_pkg::SLOT_W'((slot + 1) % count);
                r.fault            = 1'b1;
                m_faults           = sat_inc(m_faults);
            end
            m_referenced[page] = 1'b1;
            if (wr) m_modified[page] = 1'b1;
            r.phys = {m_frame[page], offset};
        end
        r.reads        = m_reads;
        r.writes       = m_writes;
        r.faults       = m_faults;
        r.dirty_evicts = m_wbs;
        return r;
    endfunction

    function automatic void check_field(string name, logic [ptfr_pkg::CNT_W-1:0] want,
                                        logic [ptfr_pkg::CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_xlat want;
        if (i_rst_n && o_done) begin
            if (expected_xlat.size() == 0) begin
                $display("%0t: result with no request pending, status %0d address 0x%0h",
                         $time, o_status, o_phys_addr);
                errors++;
            end else begin
                want = expected_xlat.pop_front();
                check_field("status", want.status, o_status);
                check_field("phys_addr", want.phys, o_phys_addr);
                check_field("fault", want.fault, o_fault);
                check_field("dirty_evict", want.dirty, o_dirty_evict);
                check_field("reads_seen", want.reads, o_reads_seen);
                check_field("writes_seen", want.writes, o_writes_seen);
                check_field("faults_seen", want.faults, o_faults_seen);
                check_field("dirty_evicts_seen", want.dirty_evicts, o_dirty_evicts_seen);
            end
        end
    end

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            start      <= 1'b0;
            i_page     <= ptfr_pkg::PAGE_W'($urandom);
            i_offset   <= ptfr_pkg::OFFSET_BITS'($urandom);
            i_is_write <= 1'($urandom);
        end
    endtask

    task automatic sender_gap();
        int n;
        n = 0;
        while (n < 20 && $urandom_range(99) < idle_pct) n++;
        idle_cycles(n);
    endtask

    task automatic send_ref(logic [ptfr_pkg::PAGE_W-1:0] page,
                            logic [ptfr_pkg::OFFSET_BITS-1:0] offset, logic wr);
        t_xlat item;
        @(negedge i_clk);
        start      <= 1'b1;
        i_page     <= page;
        i_offset   <= offset;
        i_is_write <= wr;
        do @(posedge i_clk); while (busy);
        item = translate_ref(page, offset, wr);
        expected_xlat.insert(expected_xlat.size(), item);
        n_refs++;
    endtask

    // hold off new requests until every pending result is back
    task automatic drain();
        idle_cycles(1);
        while (expected_xlat.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [ptfr_pkg::CFG_IDX_W-1:0] idx,
                             logic [ptfr_pkg::LIST_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ptfr_pkg::CFG_FRAME_LIST:  m_frame_list = data;
            ptfr_pkg::CFG_FRAME_COUNT: m_frame_count = data[ptfr_pkg::COUNT_W-1:0];
            ptfr_pkg::CFG_VALID_MASK:  m_valid_mask = data[ptfr_pkg::PAGES-1:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= {$urandom, $urandom};
    endtask

    task automatic configure(logic [ptfr_pkg::LIST_W-1:0] list,
                             logic [ptfr_pkg::LIST_W-1:0] count_word,
                             logic [ptfr_pkg::LIST_W-1:0] mask_word);
        drain();
        cfg_write(ptfr_pkg::CFG_FRAME_LIST, list);
        cfg_write(ptfr_pkg::CFG_FRAME_COUNT, count_word);
        cfg_write(ptfr_pkg::CFG_VALID_MASK, mask_word);
    endtask

    task automatic test_invalid_pages();
        send_ref(4'd0, 12'h000, 1'b0);
        send_ref(4'd15, 12'hFFF, 1'b1);
    endtask

    task automatic test_no_frames();
        configure(64'h0, 64'd0, 64'hFFFF);
        send_ref(4'd7, 12'h5A5, 1'b0);
        send_ref(4'd8, 12'hA5A, 1'b1);
    endtask

    task automatic test_fill_and_evict();
        configure(64'hF0E1_D2C3_B4A5_9687, 64'd2, 64'h7FFF);
        send_ref(4'd0, 12'h000, 1'b0);
        send_ref(4'd0, 12'hFFF, 1'b1);
        send_ref(4'd1, 12'h123, 1'b1);
        send_ref(4'd2, 12'h456, 1'b0);
        send_ref(4'd1, 12'h789, 1'b0);
        send_ref(4'd0, 12'hABC, 1'b0);
        send_ref(4'd15, 12'hFFF, 1'b1);
        send_ref(4'd1, 12'hDEF, 1'b0);
    endtask

    task automatic test_count_above_max();
        configure({ptfr_pkg::LIST_W{1'b1}}, 64'd15, 64'hFFFF);
        for (int p = 3; p <= 8; p++) begin
            send_ref(ptfr_pkg::PAGE_W'(p), ptfr_pkg::OFFSET_BITS'($urandom), 1'b1);
        end
    endtask

    task automatic test_count_lowered();
        drain();
        cfg_write(ptfr_pkg::CFG_FRAME_COUNT, 64'd2);
        send_ref(4'd9, 12'h111, 1'b0);
        send_ref(4'd10, 12'h222, 1'b1);
        send_ref(4'd11, 12'h333, 1'b0);
    endtask

    task automatic test_frame_list_changed();
        drain();
        cfg_write(ptfr_pkg::CFG_FRAME_LIST, 64'h0);
        cfg_write(CFG_UNUSED, {$urandom, $urandom});
        send_ref(4'd10, 12'h444, 1'b0);
        send_ref(4'd12, 12'h555, 1'b1);
    endtask

    task automatic test_random_phase(int phase, int pct);
        logic [ptfr_pkg::LIST_W-1:0] list;
        logic [ptfr_pkg::LIST_W-1:0] count_word;
        logic [ptfr_pkg::LIST_W-1:0] mask_word;
        logic [ptfr_pkg::PAGE_W-1:0] base;
        logic [ptfr_pkg::PAGE_W-1:0] page;
        int                          span;
        list       = {$urandom, $urandom};
        count_word = {$urandom, $urandom};
        mask_word  = {$urandom, $urandom};
        count_word[ptfr_pkg::COUNT_W-1:0] =
            ptfr_pkg::COUNT_W'($urandom_range(1, ptfr_pkg::MAX_FRAMES));
        mask_word[ptfr_pkg::PAGES-1:0] = ptfr_pkg::PAGES'($urandom | $urandom);
        case (phase)
            0: begin
                list = {ptfr_pkg::LIST_W{1'b1}};
                count_word[ptfr_pkg::COUNT_W-1:0] = ptfr_pkg::COUNT_W'(ptfr_pkg::MAX_FRAMES);
                mask_word[ptfr_pkg::PAGES-1:0] = {ptfr_pkg::PAGES{1'b1}};
            end
            1: begin
                list = '0;
                count_word[ptfr_pkg::COUNT_W-1:0] = 4'd1;
            end
            5: count_word[ptfr_pkg::COUNT_W-1:0] = ptfr_pkg::COUNT_W'($urandom_range(0, 15));
            default: ;
        endcase
        configure(list, count_word, mask_word);
        idle_pct = pct;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2) begin
                drain();
                count_word = {$urandom, $urandom};
                count_word[ptfr_pkg::COUNT_W-1:0] = ptfr_pkg::COUNT_W'($urandom_range(1, 15));
                cfg_write(ptfr_pkg::CFG_FRAME_COUNT, count_word);
                if ($urandom_range(1)) cfg_write(ptfr_pkg::CFG_FRAME_LIST, {$urandom, $urandom});
            end
            if (k % 32 == 0) base = ptfr_pkg::PAGE_W'($urandom);
            span = (m_frame_count > ptfr_pkg::MAX_FRAMES) ? ptfr_pkg::MAX_FRAMES
                                                           : int'(m_frame_count);
            if ($urandom_range(99) < 75) begin
                page = base + ptfr_pkg::PAGE_W'($urandom_range(0, span + 1));
            end else begin
                page = ptfr_pkg::PAGE_W'($urandom);
            end
            send_ref(page, ptfr_pkg::OFFSET_BITS'($urandom), 1'($urandom));
            sender_gap();
        end
    endtask

    initial begin
        int pcts [NUM_PHASES];
        pcts = '{0, 51, 20, 0, 51, 20};
        errors      = 0;
        idle_pct    = 0;
        n_refs      = 0;
        n_invalid   = 0;
        n_no_frames = 0;
        n_cfg       = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_page      = '0;
        i_offset    = '0;
        i_is_write  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        reset_model();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_invalid_pages();
        test_no_frames();
        test_fill_and_evict();
        test_count_above_max();
        test_count_lowered();
        test_frame_list_changed();
        for (int ph = 0; ph < NUM_PHASES; ph++) test_random_phase(ph, pcts[ph]);

        drain();
        repeat (10) @(posedge i_clk);
        $display("covered %0d references: %0d faults, %0d write backs, %0d invalid pages,",
                 n_refs, m_faults, m_wbs, n_invalid);
        $display("%0d with no frames, %0d config writes, sender gaps of 0/20/51 percent",
                 n_no_frames, n_cfg);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
